/* hdl/svt_pkg.sv */
// Shared types, constants and the single-to-double widening function of the shadow value table.
package svt_pkg;

  localparam int DATA_W     = 64;
  localparam int FLOAT_W    = 32;
  localparam int HASH_SHIFT = 16;

  localparam logic [26:0] HASH_MUL = 27'h45d9f3b;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  typedef enum logic [1:0] {
    KIND_STORE,
    KIND_LOAD,
    KIND_LOAD_NULL
  } kind_t;

  typedef struct packed {
    logic                cmd;
    logic [63:0]         address;
    logic [DATA_W-1:0]   shadow_bits;
    logic [FLOAT_W-1:0]  current_bits;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] value_bits;
    logic              hit;
  } result_t;

  function automatic logic [DATA_W-1:0] widen_single(input logic [FLOAT_W-1:0] b);
    logic              sign;
    logic [7:0]        e;
    logic [22:0]       m;
    logic [4:0]        s;
    logic [22:0]       mn;
    logic [DATA_W-1:0] r;
    int                i;
    sign = b[31];
    e    = b[30:23];
    m    = b[22:0];
    s    = '0;
    for (i = 0; i < 23; i++) begin
      if (m[i]) begin
        s = 5'(23 - i);
      end
    end
    mn = m << s;
    if (e == 8'hff) begin
      r = {sign, 11'h7ff, m[22] | (|m), m[21:0], 29'b0};
    end else if (e == 8'h00) begin
      if (m == '0) begin
        r = {sign, 63'b0};
      end else begin
        r = {sign, 11'd897 - {6'b0, s}, mn, 29'b0};
      end
    end else begin
      r = {sign, {3'b0, e} + 11'd896, m, 29'b0};
    end
    return r;
  endfunction

endpackage

/* hdl/shadow_value_table_unit.sv */
// Shadow value table top level: front end, decoupling queue, back end and result queue.
// Direct-mapped table of 2^INDEX_BITS slots, each holding an address tag and a 64-bit
// shadow double. Sustained rate is one request beat per cycle when neither a full queue nor
// the clearing pass holds it; the slot memory port in the back end does one store or one
// load read per cycle and sets that figure. A load result reaches the result queue through
// two front stages, the decoupling queue and the registered memory read; the tag compare
// follows the read in the same cycle. After reset the back end clears every tag, one slot
// per cycle, across all 2^INDEX_BITS slots (65536 at the default); full stays high during
// that pass. Stores give no result beat.
module shadow_value_table_unit #(
  parameter int INDEX_BITS = 16,
  parameter int ADDR_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  svt_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output svt_pkg::result_t  result
);

  localparam int ENTRY_W = $bits(svt_pkg::kind_t) + ADDR_WIDTH + INDEX_BITS +
                           svt_pkg::DATA_W;
  localparam int RES_W   = $bits(svt_pkg::result_t);

  logic               clearing;
  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_empty;
  logic               out_push;
  svt_pkg::result_t   out_item;
  logic [RES_W-1:0]   out_wdata;
  logic [RES_W-1:0]   out_rdata;
  logic               out_full;

  svt_front #(
    .INDEX_BITS (INDEX_BITS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .hold    (clearing),
    .push    (push),
    .full    (full),
    .request (request),
    .q_push  (q_push),
    .q_entry (q_wdata),
    .q_full  (q_full)
  );

  svt_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (4)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  svt_back #(
    .INDEX_BITS (INDEX_BITS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_empty  (q_empty),
    .q_entry  (q_rdata),
    .q_pop    (q_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_item (out_item)
  );

  assign out_wdata = out_item;

  svt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign result = svt_pkg::result_t'(out_rdata);

endmodule

/* hdl/svt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module svt_ram #(
  parameter  int WIDTH  = 128,
  parameter  int DEPTH  = 65536,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/svt_fifo.sv */
// Small register-based queue used between the front and back and on the result side.
module svt_fifo #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;

  assign empty = wr_ptr == rd_ptr;
  assign full  = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                 (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
  assign rdata = mem[rd_ptr[PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[PTR_W-1:0]] <= wdata;
    end
  end

endmodule

/* hdl/svt_front.sv */
// Front end: takes request beats, hashes the address, widens the float and classifies the beat.
module svt_front #(
  parameter  int INDEX_BITS = 16,
  parameter  int ADDR_WIDTH = 64,
  localparam int ENTRY_W    = $bits(svt_pkg::kind_t) + ADDR_WIDTH + INDEX_BITS +
                              svt_pkg::DATA_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                hold,
  input  logic                push,
  output logic                full,
  input  svt_pkg::request_t   request,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_entry,
  input  logic                q_full
);

  localparam int PROD_W = (ADDR_WIDTH < INDEX_BITS + svt_pkg::HASH_SHIFT) ?
                          ADDR_WIDTH : INDEX_BITS + svt_pkg::HASH_SHIFT;
  localparam int MUL_W  = $bits(svt_pkg::HASH_MUL);

  typedef struct packed {
    svt_pkg::kind_t                kind;
    logic [ADDR_WIDTH-1:0]         tag;
    logic [INDEX_BITS-1:0]         index;
    logic [svt_pkg::DATA_W-1:0]    data;
  } entry_t;

  logic                          f1_valid;
  logic                          f1_cmd;
  logic [ADDR_WIDTH-1:0]         f1_addr;
  logic [svt_pkg::DATA_W-1:0]    f1_shadow;
  logic [svt_pkg::FLOAT_W-1:0]   f1_current;

  logic                          f2_valid;
  svt_pkg::kind_t                f2_kind;
  logic [ADDR_WIDTH-1:0]         f2_addr;
  logic [PROD_W-1:0]             f2_prod;
  logic [svt_pkg::DATA_W-1:0]    f2_data;

  logic                          accept;
  logic                          f1_move;
  logic                          f1_keep;
  logic                          f2_free;
  logic                          addr_null;
  svt_pkg::kind_t                f1_kind;
  logic [svt_pkg::DATA_W-1:0]    f1_data;
  logic [ADDR_WIDTH-1:0]         k1;
  logic [PROD_W+MUL_W-1:0]       prod_full;
  logic [PROD_W-1:0]             k2;
  entry_t                        entry;

  assign f2_free = !f2_valid || !q_full;
  assign f1_move = f1_valid && f2_free;
  assign full    = hold || (f1_valid && !f2_free);
  assign accept  = push && !full;

  assign k1        = f1_addr ^ (f1_addr >> svt_pkg::HASH_SHIFT);
  assign prod_full = {{MUL_W{1'b0}}, k1[PROD_W-1:0]} * {{PROD_W{1'b0}}, svt_pkg::HASH_MUL};
  assign addr_null = f1_addr == '0;

  always_comb begin
    if (f1_cmd == svt_pkg::CMD_STORE) begin
      f1_kind = svt_pkg::KIND_STORE;
      f1_data = f1_shadow;
    end else begin
      f1_kind = addr_null ? svt_pkg::KIND_LOAD_NULL : svt_pkg::KIND_LOAD;
      f1_data = svt_pkg::widen_single(f1_current);
    end
  end

  // null stores are dropped here
  assign f1_keep = !((f1_cmd == svt_pkg::CMD_STORE) && addr_null);

  assign k2          = f2_prod ^ (f2_prod >> svt_pkg::HASH_SHIFT);
  assign entry.kind  = f2_kind;
  assign entry.tag   = f2_addr;
  assign entry.index = k2[INDEX_BITS-1:0];
  assign entry.data  = f2_data;
  assign q_entry     = entry;
  assign q_push      = f2_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (accept) begin
        f1_valid <= 1'b1;
      end else if (f1_move) begin
        f1_valid <= 1'b0;
      end
      if (f1_move) begin
        f2_valid <= f1_keep;
      end else if (q_push) begin
        f2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_cmd     <= request.cmd;
      f1_addr    <= request.address[ADDR_WIDTH-1:0];
      f1_shadow  <= request.shadow_bits;
      f1_current <= request.current_bits;
    end
    if (f1_move) begin
      f2_kind <= f1_kind;
      f2_addr <= f1_addr;
      f2_prod <= prod_full[PROD_W-1:0];
      f2_data <= f1_data;
    end
  end

endmodule

/* hdl/svt_back.sv */
// Back end: owns the slot memory, clears it after reset, performs stores and resolves loads.
module svt_back #(
  parameter  int INDEX_BITS = 16,
  parameter  int ADDR_WIDTH = 64,
  localparam int ENTRY_W    = $bits(svt_pkg::kind_t) + ADDR_WIDTH + INDEX_BITS +
                              svt_pkg::DATA_W
) (
  input  logic               clk,
  input  logic               rst,
  output logic               clearing,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_entry,
  output logic               q_pop,
  input  logic               out_full,
  output logic               out_push,
  output svt_pkg::result_t   out_item
);

  localparam int SLOT_W = ADDR_WIDTH + svt_pkg::DATA_W;

  typedef struct packed {
    svt_pkg::kind_t                kind;
    logic [ADDR_WIDTH-1:0]         tag;
    logic [INDEX_BITS-1:0]         index;
    logic [svt_pkg::DATA_W-1:0]    data;
  } entry_t;

  entry_t                        head;
  logic                          head_store;
  logic                          pop_load;
  logic                          b2_free;

  logic                          clr_active;
  logic [INDEX_BITS-1:0]         clr_idx;

  logic                          b2_valid;
  svt_pkg::kind_t                b2_kind;
  logic [ADDR_WIDTH-1:0]         b2_tag;
  logic [svt_pkg::DATA_W-1:0]    b2_data;

  logic                          ram_we;
  logic [INDEX_BITS-1:0]         ram_waddr;
  logic [SLOT_W-1:0]             ram_wdata;
  logic                          ram_re;
  logic [SLOT_W-1:0]             ram_rdata;
  logic [ADDR_WIDTH-1:0]         rd_tag;
  logic [svt_pkg::DATA_W-1:0]    rd_value;
  logic                          hit;

  assign head       = entry_t'(q_entry);
  assign head_store = head.kind == svt_pkg::KIND_STORE;
  assign b2_free    = !b2_valid || !out_full;
  assign q_pop      = !q_empty && !clr_active && (head_store || b2_free);
  assign pop_load   = q_pop && !head_store;

  assign ram_we    = clr_active || (q_pop && head_store);
  assign ram_waddr = clr_active ? clr_idx : head.index;
  assign ram_wdata = clr_active ? '0 : {head.tag, head.data};
  assign ram_re    = pop_load;

  svt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (1 << INDEX_BITS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head.index),
    .rdata (ram_rdata)
  );

  assign rd_tag   = ram_rdata[SLOT_W-1:svt_pkg::DATA_W];
  assign rd_value = ram_rdata[svt_pkg::DATA_W-1:0];
  assign hit      = (b2_kind == svt_pkg::KIND_LOAD) && (rd_tag == b2_tag);

  assign out_push            = b2_valid && !out_full;
  assign out_item.value_bits = hit ? rd_value : b2_data;
  assign out_item.hit        = hit;
  assign clearing            = clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
      b2_valid   <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == '1) begin
          clr_active <= 1'b0;
        end
      end
      if (pop_load) begin
        b2_valid <= 1'b1;
      end else if (out_push) begin
        b2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_load) begin
      b2_kind <= head.kind;
      b2_tag  <= head.tag;
      b2_data <= head.data;
    end
  end

`ifndef SYNTH
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("slot memory read and written in the same cycle");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_b2_hold: assert property (@(posedge clk) disable iff (rst)
    (b2_valid && out_full) |=> (b2_valid && $stable(b2_tag) && $stable(b2_data)))
    else $error("stalled load lost its contents");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_active) |-> ($past(clr_idx) == '1))
    else $error("clearing pass ended early");
`endif

endmodule

/* tb/sv/shadow_value_table_checker.sv */
// Checker for the shadow value table: mirrors the slot table, predicts load results, compares result beats.
module shadow_value_table_checker #(
  parameter int INDEX_BITS = 16,
  parameter int ADDR_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  svt_pkg::request_t request,
  input  logic              empty,
  input  logic              pop,
  input  svt_pkg::result_t  result,
  output int                mismatches,
  output int                loads_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import svt_pkg::*;

  localparam int          SLOTS    = 1 << INDEX_BITS;
  localparam logic [63:0] KEY_MASK = ~64'd0 >> (64 - ADDR_WIDTH);
  localparam logic [63:0] MIX_MUL  = 64'h45d9f3b;

  logic [63:0] slot_tag   [SLOTS];
  logic [63:0] slot_value [SLOTS];
  result_t     awaited_loads [$];
  int          miss_count = 0;

  initial begin
    mismatches      = 0;
    loads_in_flight = 0;
  end

  function automatic int unsigned slot_for(input logic [63:0] key);
    logic [63:0] k;
    k = key & KEY_MASK;
    k = k ^ (k >> 16);
    k = (k * MIX_MUL) & KEY_MASK;
    k = k ^ (k >> 16);
    return int'(k & 64'(SLOTS - 1));
  endfunction

  function automatic logic [63:0] single_to_double(input logic [31:0] f);
    logic [7:0]  ex;
    logic [23:0] man;
    logic [10:0] dexp;
    int          shift;
    ex  = f[30:23];
    man = {1'b0, f[22:0]};
    if (ex == 8'hff) begin
      return {f[31], 11'h7ff, man[22] | (|man), man[21:0], 29'b0};
    end
    if (ex == 8'h00) begin
      if (man == '0) begin
        return {f[31], 63'b0};
      end
      shift = 0;
      while (!man[23]) begin
        man   = man << 1;
        shift = shift + 1;
      end
      dexp = 11'(897 - shift);
      return {f[31], dexp, man[22:0], 29'b0};
    end
    dexp = {3'b0, ex} + 11'd896;
    return {f[31], dexp, man[22:0], 29'b0};
  endfunction

  function automatic result_t predict_load(input request_t beat);
    result_t     r;
    logic [63:0] key;
    int unsigned idx;
    key          = beat.address & KEY_MASK;
    r.value_bits = single_to_double(beat.current_bits);
    r.hit        = 1'b0;
    if (key != '0) begin
      idx = slot_for(key);
      if (slot_tag[idx] == key) begin
        r.value_bits = slot_value[idx];
        r.hit        = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    miss_count = miss_count + 1;
    if (miss_count <= 10) begin
      $display("%0t mismatch, %s: expected %h, actual %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t     want;
    logic [63:0] key;
    int unsigned idx;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_tag[i]   = '0;
        slot_value[i] = '0;
      end
      awaited_loads.delete();
    end else begin
      // a result beat always leaves after the push of its request, so check it first
      if (pop && !empty) begin
        if (awaited_loads.size() == 0) begin
          report_mismatch("result beat with no load waiting", 64'bx, result.value_bits);
        end else begin
          want = awaited_loads.pop_front();
          if (result.value_bits !== want.value_bits) begin
            report_mismatch("value_bits", want.value_bits, result.value_bits);
          end
          if (result.hit !== want.hit) begin
            report_mismatch("hit", 64'(want.hit), 64'(result.hit));
          end
        end
      end
      if (push && !full) begin
        if (request.cmd == CMD_LOAD) begin
          awaited_loads.push_back(predict_load(request));
        end else begin
          key = request.address & KEY_MASK;
          if (key != '0) begin
            idx             = slot_for(key);
            slot_tag[idx]   = key;
            slot_value[idx] = request.shadow_bits;
          end
        end
      end
    end
    mismatches      <= miss_count;
    loads_in_flight <= awaited_loads.size();
  end

endmodule

/* tb/sv/shadow_value_table_unit_test.sv */
// Testbench top for the shadow value table unit: request and result stimulus, watchdog and verdict.
module shadow_value_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import svt_pkg::*;

  localparam int          RANDOM_BEATS  = 600;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 12;
  localparam logic [63:0] ALIAS_BIT     = 64'h0001_0000_0000_0000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        push     = 1'b0;
  logic        full;
  request_t    req_beat = '0;
  logic        empty;
  logic        pop      = 1'b0;
  result_t     res_beat;
  int          mismatches;
  int          loads_in_flight;
  int          cycles   = 0;
  bit          push_steady = 1'b0;
  bit          pop_steady  = 1'b0;
  logic [63:0] stored_keys [$];

  shadow_value_table_unit dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (req_beat),
    .empty   (empty),
    .pop     (pop),
    .result  (res_beat)
  );

  shadow_value_table_checker load_check (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .request         (req_beat),
    .empty           (empty),
    .pop             (pop),
    .result          (res_beat),
    .mismatches      (mismatches),
    .loads_in_flight (loads_in_flight)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // idle cycles before the next beat; occasionally flips into or out of a back-to-back stretch
  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 31) == 0) begin
      steady = !steady;
    end
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [31:0] pick_single();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(0, 9))
      5: bits[30:23] = 8'hff;
      6: bits[30:23] = 8'h00;
      7: begin
        bits[22:0]  = '0;
        bits[30:23] = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
      end
      8: begin
        bits[30:23] = 8'h00;
        bits[22:0]  = 23'd1 << $urandom_range(0, 22);
      end
      default: ;
    endcase
    return bits;
  endfunction

  // keys differing only in bits 63:48 share a slot, so aliases force tag mismatches
  function automatic logic [63:0] pick_key();
    int          roll;
    logic [63:0] key;
    roll = $urandom_range(0, 99);
    key  = {$urandom, $urandom};
    if (roll < 4) begin
      key = '0;
    end else if (stored_keys.size() > 0 && roll < 55) begin
      key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end else if (stored_keys.size() > 0 && roll < 75) begin
      key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
            ^ {16'($urandom_range(1, 16'hffff)), 48'd0};
    end else if (roll < 85) begin
      key = 64'($urandom_range(1, 255));
    end
    return key;
  endfunction

  task automatic send_beat(input logic op, input logic [63:0] key,
                           input logic [63:0] shadow, input logic [31:0] single);
    int gap;
    gap = draw_wait(push_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    req_beat <= '{cmd: op, address: key, shadow_bits: shadow, current_bits: single};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  initial begin
    int          sent;
    logic [63:0] key;
    logic [63:0] key_a;
    logic [63:0] unused_key;
    key_a      = 64'h0000_0000_0000_0001;
    unused_key = 64'h1234_5678_9abc_def0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // null address, extremes, aliasing and widening corners
    send_beat(CMD_LOAD, '0, '0, 32'h0000_0000);
    send_beat(CMD_STORE, '0, {64{1'b1}}, 32'h0);
    send_beat(CMD_LOAD, '0, '0, 32'h8000_0000);
    send_beat(CMD_STORE, key_a, {64{1'b1}}, '0);
    send_beat(CMD_LOAD, key_a, '0, 32'hffff_ffff);
    send_beat(CMD_STORE, {64{1'b1}}, '0, '0);
    send_beat(CMD_LOAD, {64{1'b1}}, {64{1'b1}}, '0);
    send_beat(CMD_LOAD, key_a ^ ALIAS_BIT, '0, 32'h7f80_0000);
    send_beat(CMD_STORE, key_a ^ ALIAS_BIT, 64'h5555_5555_5555_5555, '0);
    send_beat(CMD_LOAD, key_a, '0, 32'hff80_0000);
    send_beat(CMD_LOAD, key_a ^ ALIAS_BIT, '0, '0);
    send_beat(CMD_LOAD, unused_key, '0, 32'h7fc0_0001);
    send_beat(CMD_LOAD, unused_key, '0, 32'hffa0_0000);
    send_beat(CMD_LOAD, unused_key, '0, 32'h0000_0001);
    send_beat(CMD_LOAD, unused_key, '0, 32'h807f_ffff);
    send_beat(CMD_LOAD, unused_key, '0, 32'h7f7f_ffff);
    send_beat(CMD_LOAD, unused_key, '0, 32'h0080_0000);
    send_beat(CMD_LOAD, unused_key, '0, 32'h3f80_0000);
    send_beat(CMD_STORE, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa, '0);
    send_beat(CMD_LOAD, 64'h8000_0000_0000_0000, '0, 32'h0);
    send_beat(CMD_STORE, key_a, 64'h0000_0000_0000_0001, '0);
    send_beat(CMD_LOAD, key_a, '0, '0);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      key = pick_key();
      if ($urandom_range(0, 99) < 45) begin
        send_beat(CMD_STORE, key, {$urandom, $urandom}, $urandom);
        if (key != '0) begin
          sent = sent + 1;
          stored_keys.push_back(key);
          if (stored_keys.size() > 48) begin
            void'(stored_keys.pop_front());
          end
        end
      end else begin
        send_beat(CMD_LOAD, key, {$urandom, $urandom}, pick_single());
        sent = sent + 1;
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (loads_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      wait_cycles = draw_wait(pop_steady);
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

endmodule

/* filelist.f */
hdl/svt_pkg.sv
hdl/svt_ram.sv
hdl/svt_fifo.sv
hdl/svt_front.sv
hdl/svt_back.sv
hdl/shadow_value_table_unit.sv
tb/sv/shadow_value_table_checker.sv
tb/sv/shadow_value_table_unit_test.sv
